FILE: design/bounded_indexed_list_engine_macros.svh
// assertion macros shared by the list engine
`ifndef BOUNDED_INDEXED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_INDEXED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define BILE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bile: same-cycle check failed");
`define BILE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bile: next-cycle check failed");
`else
`define BILE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BILE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/bile_pkg.sv
package bile_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int FUNC_W       = 3;
	localparam int VALUE_W      = 32;

	localparam logic [FUNC_W-1:0] FUNC_SELECT  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_REPLACE = 3'd4;

	// cursor load source
	typedef enum logic [1:0] {CUR_ZERO, CUR_POS, CUR_CNT, CUR_SEL} cur_sel_t;
	// read address relative to the cursor
	typedef enum logic [1:0] {RA_CUR, RA_DEC, RA_INC} ra_sel_t;
	typedef enum logic {WA_LAG, WA_POS} wa_sel_t;
	typedef enum logic {WD_RDATA, WD_VAL} wd_sel_t;
	typedef enum logic {FND_LAG, FND_CNT} fnd_sel_t;

	typedef struct packed {
		logic     accept;
		logic     cur_ld;
		cur_sel_t cur_sel;
		logic     cur_inc;
		logic     cur_dec;
		logic     rd_en;
		ra_sel_t  ra_sel;
		logic     wr_en;
		wa_sel_t  wa_sel;
		wd_sel_t  wd_sel;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     res_clr;
		logic     ok_set;
		logic     rd_ld;
		logic     found_ld;
		fnd_sel_t found_sel;
		logic     out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              count_zero;
		logic              full;
		logic              pos_lt_cnt;
		logic              pos_le_cnt;
		logic              cur_eq_pos;
		logic              cur_eq_cnt;
		logic              rem_more;
		logic              match;
	} dp_sts_t;

endpackage

FILE: design/bile_dp.sv
module bile_dp #(
	parameter int CAPACITY = bile_pkg::CAPACITY_DEF,
	localparam int POS_W  = $clog2(CAPACITY + 1),
	localparam int ADDR_W = $clog2(CAPACITY),
	localparam int IN_W   = ((bile_pkg::FUNC_W + POS_W + bile_pkg::VALUE_W + 7) / 8) * 8,
	localparam int OUT_W  = ((bile_pkg::VALUE_W + 2 * POS_W + 3 + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IN_W-1:0]   s_tdata,
	output logic [OUT_W-1:0]  m_tdata,
	input  bile_pkg::dp_cmd_t cmd,
	output bile_pkg::dp_sts_t sts
);
	import bile_pkg::*;

	logic [VALUE_W-1:0] mem [CAPACITY];

	logic [FUNC_W-1:0]         func_q;
	logic [POS_W-1:0]          pos_q;
	logic [VALUE_W-1:0]        val_q;
	logic [POS_W-1:0]          count_q;
	logic [POS_W-1:0]          cur_q;
	logic [ADDR_W-1:0]         lag_q;
	logic [VALUE_W-1:0]        rdata_q;
	logic                      ok_q;
	logic signed [VALUE_W-1:0] rd_q;
	logic [POS_W-1:0]          found_q;

	logic                      out_ok_q;
	logic signed [VALUE_W-1:0] out_rd_q;
	logic [POS_W-1:0]          out_found_q;
	logic [POS_W-1:0]          out_count_q;
	logic                      out_empty_q;
	logic                      out_full_q;

	logic [POS_W-1:0]   sel_addr;
	logic [POS_W-1:0]   cur_nxt;
	logic [POS_W-1:0]   ra_full;
	logic [ADDR_W-1:0]  raddr;
	logic [ADDR_W-1:0]  waddr;
	logic [VALUE_W-1:0] wdata;
	logic               full;

	assign full = (count_q == POS_W'(CAPACITY));

	assign sts.func       = func_q;
	assign sts.count_zero = (count_q == '0);
	assign sts.full       = full;
	assign sts.pos_lt_cnt = (pos_q < count_q);
	assign sts.pos_le_cnt = (pos_q <= count_q);
	assign sts.cur_eq_pos = (cur_q == pos_q);
	assign sts.cur_eq_cnt = (cur_q == count_q);
	assign sts.rem_more   = ((cur_q + POS_W'(1)) < count_q);
	assign sts.match      = (rdata_q == val_q);

	// select past the end reads the last entry
	assign sel_addr = (pos_q < count_q) ? pos_q : (count_q - POS_W'(1));

	always_comb begin
		case (cmd.cur_sel)
			CUR_ZERO: cur_nxt = '0;
			CUR_POS:  cur_nxt = pos_q;
			CUR_CNT:  cur_nxt = count_q;
			CUR_SEL:  cur_nxt = sel_addr;
			default:  cur_nxt = '0;
		endcase
	end

	always_comb begin
		case (cmd.ra_sel)
			RA_CUR:  ra_full = cur_q;
			RA_DEC:  ra_full = cur_q - POS_W'(1);
			RA_INC:  ra_full = cur_q + POS_W'(1);
			default: ra_full = cur_q;
		endcase
	end

	assign raddr = ra_full[ADDR_W-1:0];
	assign waddr = (cmd.wa_sel == WA_POS) ? pos_q[ADDR_W-1:0] : lag_q;
	assign wdata = (cmd.wd_sel == WD_VAL) ? val_q : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + POS_W'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= s_tdata[FUNC_W-1:0];
			pos_q  <= s_tdata[FUNC_W +: POS_W];
			val_q  <= s_tdata[FUNC_W + POS_W +: VALUE_W];
		end
		if (cmd.cur_ld) begin
			cur_q <= cur_nxt;
		end else if (cmd.cur_inc) begin
			cur_q <= cur_q + POS_W'(1);
		end else if (cmd.cur_dec) begin
			cur_q <= cur_q - POS_W'(1);
		end
		// lag remembers the entry that the pending read belongs to
		if (cmd.rd_en) begin
			lag_q <= cur_q[ADDR_W-1:0];
		end
		if (cmd.res_clr) begin
			ok_q    <= 1'b0;
			rd_q    <= '0;
			found_q <= '0;
		end
		if (cmd.ok_set) begin
			ok_q <= 1'b1;
		end
		if (cmd.rd_ld) begin
			rd_q <= rdata_q;
		end
		if (cmd.found_ld) begin
			found_q <= (cmd.found_sel == FND_CNT) ? count_q : POS_W'(lag_q);
		end
		if (cmd.out_ld) begin
			out_ok_q    <= ok_q;
			out_rd_q    <= rd_q;
			out_found_q <= found_q;
			out_count_q <= count_q;
			out_empty_q <= (count_q == '0);
			out_full_q  <= full;
		end
	end

	// ok, read_value, found_index, count, is_empty, is_full from bit 0 up
	assign m_tdata = OUT_W'({out_full_q, out_empty_q, out_count_q, out_found_q,
		out_rd_q, out_ok_q});

endmodule

FILE: design/bile_ctrl.sv
module bile_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output bile_pkg::dp_cmd_t cmd,
	input  bile_pkg::dp_sts_t sts
);
	import bile_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DEC, ST_SEL_RD, ST_SEL_WT, ST_SRCH, ST_INS, ST_REM, ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   pend_q;
	logic   pend_d;
	logic   m_tvalid_q;
	logic   m_tvalid_d;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		pend_d  = pend_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DEC;
				end
			end
			ST_DEC: begin
				cmd.res_clr = 1'b1;
				pend_d      = 1'b0;
				state_d     = ST_FIN;
				case (sts.func)
					FUNC_SELECT: begin
						if (!sts.count_zero) begin
							cmd.cur_ld  = 1'b1;
							cmd.cur_sel = CUR_SEL;
							state_d     = ST_SEL_RD;
						end
					end
					FUNC_SEARCH: begin
						cmd.cur_ld  = 1'b1;
						cmd.cur_sel = CUR_ZERO;
						state_d     = ST_SRCH;
					end
					FUNC_INSERT: begin
						if (!sts.full && sts.pos_le_cnt) begin
							cmd.cur_ld  = 1'b1;
							cmd.cur_sel = CUR_CNT;
							state_d     = ST_INS;
						end
					end
					FUNC_REMOVE: begin
						if (sts.pos_lt_cnt) begin
							cmd.cur_ld  = 1'b1;
							cmd.cur_sel = CUR_POS;
							state_d     = ST_REM;
						end
					end
					FUNC_REPLACE: begin
						if (sts.pos_lt_cnt) begin
							cmd.wr_en  = 1'b1;
							cmd.wa_sel = WA_POS;
							cmd.wd_sel = WD_VAL;
							cmd.ok_set = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SEL_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.ra_sel = RA_CUR;
				state_d    = ST_SEL_WT;
			end
			ST_SEL_WT: begin
				cmd.rd_ld = 1'b1;
				state_d   = ST_FIN;
			end
			ST_SRCH: begin
				// compare runs one entry behind the read
				if (pend_q && sts.match) begin
					cmd.found_ld  = 1'b1;
					cmd.found_sel = FND_LAG;
					pend_d        = 1'b0;
					state_d       = ST_FIN;
				end else if (sts.cur_eq_cnt) begin
					cmd.found_ld  = 1'b1;
					cmd.found_sel = FND_CNT;
					pend_d        = 1'b0;
					state_d       = ST_FIN;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.ra_sel  = RA_CUR;
					cmd.cur_inc = 1'b1;
					pend_d      = 1'b1;
				end
			end
			ST_INS: begin
				// shift down from the end, each write lands in the cycle after its read
				if (pend_q) begin
					cmd.wr_en  = 1'b1;
					cmd.wa_sel = WA_LAG;
					cmd.wd_sel = WD_RDATA;
				end
				if (!sts.cur_eq_pos) begin
					cmd.rd_en   = 1'b1;
					cmd.ra_sel  = RA_DEC;
					cmd.cur_dec = 1'b1;
					pend_d      = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						cmd.wr_en   = 1'b1;
						cmd.wa_sel  = WA_POS;
						cmd.wd_sel  = WD_VAL;
						cmd.cnt_inc = 1'b1;
						cmd.ok_set  = 1'b1;
						state_d     = ST_FIN;
					end
				end
			end
			ST_REM: begin
				if (pend_q) begin
					cmd.wr_en  = 1'b1;
					cmd.wa_sel = WA_LAG;
					cmd.wd_sel = WD_RDATA;
				end
				if (sts.rem_more) begin
					cmd.rd_en   = 1'b1;
					cmd.ra_sel  = RA_INC;
					cmd.cur_inc = 1'b1;
					pend_d      = 1'b1;
				end else begin
					pend_d = 1'b0;
					if (!pend_q) begin
						cmd.cnt_dec = 1'b1;
						cmd.ok_set  = 1'b1;
						state_d     = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.out_ld) begin
			m_tvalid_d = 1'b1;
		end else if (m_tready) begin
			m_tvalid_d = 1'b0;
		end else begin
			m_tvalid_d = m_tvalid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_q     <= pend_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

endmodule

FILE: design/bounded_indexed_list_engine.sv
// one transaction at a time; the next is taken at the edge after its result is registered
// search reads from the front until a match or the end of the list; insert moves the entries
// from the position to the end one place up, remove moves those after the position one place down
// a stalled result holds the engine waiting
// reset clears the entry count, the controller and the output valid;
// list memory is not cleared, an entry is only read after it was written
`include "bounded_indexed_list_engine_macros.svh"

module bounded_indexed_list_engine #(
	parameter int CAPACITY = bile_pkg::CAPACITY_DEF,
	localparam int POS_W  = $clog2(CAPACITY + 1),
	localparam int IN_W   = ((bile_pkg::FUNC_W + POS_W + bile_pkg::VALUE_W + 7) / 8) * 8,
	localparam int OUT_W  = ((bile_pkg::VALUE_W + 2 * POS_W + 3 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // func, position, item_value
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // ok, read_value, found_index, count, is_empty, is_full
);
	import bile_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	logic [POS_W-1:0] m_count;
	logic             m_is_empty;
	logic             m_is_full;

	bile_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	bile_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.sts     (sts)
	);

	assign m_count    = m_tdata[VALUE_W + 1 + POS_W +: POS_W];
	assign m_is_empty = m_tdata[VALUE_W + 1 + 2 * POS_W];
	assign m_is_full  = m_tdata[VALUE_W + 2 + 2 * POS_W];

	`BILE_ASSERT_IMP(a_count_bound, clk, arst_n, m_tvalid, m_count <= POS_W'(CAPACITY))
	`BILE_ASSERT_IMP(a_empty_flag, clk, arst_n, m_tvalid, m_is_empty == (m_count == '0))
	`BILE_ASSERT_IMP(a_full_flag, clk, arst_n, m_tvalid, m_is_full == (m_count == POS_W'(CAPACITY)))
	`BILE_ASSERT_NXT(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`BILE_ASSERT_IMP(a_no_write_idle, clk, arst_n, cmd.wr_en, !s_tready)

endmodule

FILE: tb/sv/tb_bounded_indexed_list_engine.sv
module tb_bounded_indexed_list_engine;
	import bile_pkg::*;

	localparam int LIST_CAP  = CAPACITY_DEF;
	localparam int IN_W      = 48;
	localparam int OUT_W     = 56;
	localparam int DRAIN_CYC = 120;

	// codes past replace do nothing
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

	localparam logic [31:0] VAL_MIN = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [31:0] VAL_NEG = 32'hffff_ffff;

	typedef struct packed {
		logic        ok;
		logic [31:0] read_value;
		logic [6:0]  found_index;
		logic [6:0]  count;
		logic        is_empty;
		logic        is_full;
	} list_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// predictor state
	logic [31:0]  list_mem [LIST_CAP];
	int           list_len = 0;
	list_result_t pending_results [$];

	bit no_idle = 1'b0;
	int requests_sent = 0;
	int results_checked = 0;
	int fault_count = 0;
	int full_results = 0;

	bounded_indexed_list_engine #(.CAPACITY(LIST_CAP)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // func, position, item_value
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // ok, read_value, found_index, count, is_empty, is_full
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic list_result_t apply_request(logic [FUNC_W-1:0] func, logic [6:0] pos,
			logic [31:0] val);
		list_result_t r;
		int i;
		r = '0;
		case (func)
			FUNC_SELECT: begin
				if (list_len != 0)
					r.read_value = (pos < list_len) ? list_mem[pos] : list_mem[list_len-1];
			end
			FUNC_SEARCH: begin
				r.found_index = list_len[6:0];
				for (i = list_len - 1; i >= 0; i--)
					if (list_mem[i] == val)
						r.found_index = i[6:0];
			end
			FUNC_INSERT: begin
				if (list_len < LIST_CAP && pos <= list_len) begin
					for (i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = val;
					list_len++;
					r.ok = 1'b1;
				end
			end
			FUNC_REMOVE: begin
				if (pos < list_len) begin
					for (i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
					r.ok = 1'b1;
				end
			end
			FUNC_REPLACE: begin
				if (pos < list_len) begin
					list_mem[pos] = val;
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.count    = list_len[6:0];
		r.is_empty = (list_len == 0);
		r.is_full  = (list_len == LIST_CAP);
		return r;
	endfunction

	// weighted values hit edge cases and duplicates more often
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return VAL_NEG;
			3: return 32'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [6:0] pick_position(logic [FUNC_W-1:0] func);
		int top;
		if ($urandom_range(0, 9) == 0)
			return 7'($urandom_range(0, LIST_CAP));
		top = (func == FUNC_INSERT) ? list_len : list_len - 1;
		if (top < 0)
			return 7'd0;
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return 7'(top);
			default: return 7'($urandom_range(0, top));
		endcase
	endfunction

	task automatic send_request(logic [FUNC_W-1:0] func, logic [6:0] pos, logic [31:0] val);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			if (s_tvalid)
				s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, val, pos, func};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_request(func, pos, val));
		requests_sent++;
	endtask

	task automatic release_input();
		if (s_tvalid)
			s_tvalid <= 1'b0;
	endtask

	task automatic test_directed();
		int k;
		// empty list
		send_request(FUNC_SELECT, 7'd0, 32'd0);
		send_request(FUNC_SEARCH, 7'd0, 32'd5);
		send_request(FUNC_REMOVE, 7'd0, 32'd0);
		send_request(FUNC_REPLACE, 7'd0, 32'd9);
		send_request(FUNC_INSERT, 7'd1, 32'd9);
		// front, back and middle inserts, then one past the end
		send_request(FUNC_INSERT, 7'd0, VAL_MIN);
		send_request(FUNC_INSERT, 7'd1, VAL_MAX);
		send_request(FUNC_INSERT, 7'd0, VAL_NEG);
		send_request(FUNC_INSERT, 7'd1, 32'd0);
		send_request(FUNC_INSERT, 7'd5, 32'd1);
		send_request(FUNC_SELECT, 7'd0, 32'd0);
		send_request(FUNC_SELECT, 7'd3, 32'd0);
		// past the end gives the last entry
		send_request(FUNC_SELECT, 7'd64, 32'd0);
		send_request(FUNC_SEARCH, 7'd0, VAL_MIN);
		send_request(FUNC_SEARCH, 7'd0, 32'd12345);
		send_request(FUNC_INSERT, 7'd4, VAL_NEG);
		// duplicate value, first one wins
		send_request(FUNC_SEARCH, 7'd0, VAL_NEG);
		send_request(FUNC_REPLACE, 7'd2, 32'd7);
		send_request(FUNC_REPLACE, 7'd5, 32'd7);
		send_request(FUNC_REMOVE, 7'd4, 32'd0);
		send_request(FUNC_REMOVE, 7'd4, 32'd0);
		send_request(FUNC_REMOVE, 7'd0, 32'd0);
		for (k = FUNC_UNUSED_FIRST; k <= FUNC_UNUSED_LAST; k++)
			send_request(FUNC_W'(k), 7'd64, VAL_NEG);
		release_input();
	endtask

	task automatic test_fill_and_empty();
		while (list_len < LIST_CAP)
			send_request(FUNC_INSERT, 7'($urandom_range(0, list_len)), pick_value());
		// full list refuses inserts at either end
		send_request(FUNC_INSERT, 7'd0, 32'd1);
		send_request(FUNC_INSERT, 7'd64, 32'd1);
		send_request(FUNC_SELECT, 7'd63, 32'd0);
		send_request(FUNC_SELECT, 7'd64, 32'd0);
		send_request(FUNC_SEARCH, 7'd0, list_mem[LIST_CAP-1]);
		send_request(FUNC_SEARCH, 7'd0, $urandom);
		send_request(FUNC_REPLACE, 7'd63, $urandom);
		send_request(FUNC_REPLACE, 7'd64, $urandom);
		send_request(FUNC_REMOVE, 7'd64, 32'd0);
		while (list_len > 0) begin
			case ($urandom_range(0, 2))
				0: send_request(FUNC_REMOVE, 7'd0, $urandom);
				1: send_request(FUNC_REMOVE, 7'(list_len - 1), $urandom);
				default: send_request(FUNC_REMOVE, 7'($urandom_range(0, list_len - 1)),
						$urandom);
			endcase
		end
		send_request(FUNC_REMOVE, 7'd0, 32'd0);
		send_request(FUNC_SELECT, 7'd64, 32'd0);
		release_input();
	endtask

	task automatic test_random_ops(int n_items);
		int k, r, grow_w;
		logic [FUNC_W-1:0] func;
		logic [31:0] val;
		grow_w = 28;
		for (k = 0; k < n_items; k++) begin
			// phases that push the count up, down or let it wander
			if (k % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: grow_w = 45;
					1: grow_w = 10;
					default: grow_w = 28;
				endcase
			end
			if ($urandom_range(0, 99) < 3)
				no_idle = !no_idle;
			r = $urandom_range(0, 99);
			if (r < 3)
				func = FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
			else if (r < 18)
				func = FUNC_SELECT;
			else if (r < 33)
				func = FUNC_SEARCH;
			else if (r < 45)
				func = FUNC_REPLACE;
			else if (r < 45 + grow_w)
				func = FUNC_INSERT;
			else
				func = FUNC_REMOVE;
			if (func == FUNC_SEARCH && list_len > 0 && $urandom_range(0, 9) < 6)
				val = list_mem[$urandom_range(0, list_len - 1)];
			else
				val = pick_value();
			send_request(func, pick_position(func), val);
		end
		no_idle = 1'b0;
		release_input();
	endtask

	// result side: random stalls, then check each transaction against the oldest prediction
	initial begin : result_sink
		int stall;
		list_result_t want, got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				if (m_tready)
					m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			if (!m_tready)
				m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.ok          = m_tdata[0];
			got.read_value  = m_tdata[32:1];
			got.found_index = m_tdata[39:33];
			got.count       = m_tdata[46:40];
			got.is_empty    = m_tdata[47];
			got.is_full     = m_tdata[48];
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: ok=%0d rd=%h found=%0d cnt=%0d e=%0d f=%0d",
						got.ok, got.read_value, got.found_index, got.count,
						got.is_empty, got.is_full);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (want.is_full)
					full_results++;
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("mismatch at result %0d:", results_checked);
						$display("  exp ok=%0d rd=%h found=%0d cnt=%0d e=%0d f=%0d",
							want.ok, want.read_value, want.found_index, want.count,
							want.is_empty, want.is_full);
						$display("  got ok=%0d rd=%h found=%0d cnt=%0d e=%0d f=%0d",
							got.ok, got.read_value, got.found_index, got.count,
							got.is_empty, got.is_full);
					end
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_bounded_indexed_list_engine: done, errors");
		$finish;
	end

	initial begin
		int waited;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_empty();
		test_random_ops(1700);
		waited = 0;
		while (pending_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYC) @(posedge clk);
		fault_count += pending_results.size();
		$display("%0d requests over all five operations and the unused codes, %0d results checked",
			requests_sent, results_checked);
		$display("list filled to capacity in %0d results, %0d faults", full_results, fault_count);
		if (fault_count == 0)
			$display("tb_bounded_indexed_list_engine: done, clean");
		else
			$display("tb_bounded_indexed_list_engine: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/bile_pkg.sv
design/bile_dp.sv
design/bile_ctrl.sv
design/bounded_indexed_list_engine.sv
tb/sv/tb_bounded_indexed_list_engine.sv
